FILE: design/frac_pkg.sv
package frac_pkg;

  // request from the sequencer to an arithmetic unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  // status returned by an arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

FILE: design/frac_in_if.sv
interface frac_in_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] numerator;
  logic [VALUE_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

FILE: design/frac_out_if.sv
interface frac_out_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] reduced_numerator;
  logic [VALUE_WIDTH-1:0] reduced_denominator;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  output ready);
endinterface

FILE: design/frac_gcd.sv
module frac_gcd #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  frac_pkg::unit_ctl_t    ctl,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output frac_pkg::unit_sts_t    sts,
  output logic [VALUE_WIDTH-1:0] g
);

  localparam int KW = (VALUE_WIDTH > 2) ? $clog2(VALUE_WIDTH) : 1;

  typedef enum logic [1:0] {
    G_IDLE,
    G_TWOS,
    G_RUN,
    G_FIX
  } gcd_state_t;

  gcd_state_t             state;
  logic [VALUE_WIDTH-1:0] u;
  logic [VALUE_WIDTH-1:0] v;
  logic [KW-1:0]          k;
  logic                   done;
  logic [VALUE_WIDTH:0]   diff;

  assign diff = {1'b0, u} - {1'b0, v};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == G_FIX) && (k == '0);
      unique case (state)
        G_IDLE: begin
          if (ctl.start) begin
            u     <= a;
            v     <= b;
            k     <= '0;
            state <= G_TWOS;
          end
        end
        // strip the common factors of two, counted in k
        G_TWOS: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else begin
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (v == '0) begin
            state <= G_FIX;
          end else if (u == '0) begin
            u     <= v;
            state <= G_FIX;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (diff[VALUE_WIDTH]) begin
            v <= (v - u) >> 1;
          end else begin
            u <= diff[VALUE_WIDTH-1:0] >> 1;
          end
        end
        // restore the common powers of two one shift at a time
        G_FIX: begin
          if (k == '0) begin
            state <= G_IDLE;
          end else begin
            u <= u << 1;
            k <= k - 1'b1;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign g        = u;
  assign sts.done = done;
  assign sts.busy = (state != G_IDLE);

endmodule

FILE: design/frac_div.sv
module frac_div #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  frac_pkg::unit_ctl_t    ctl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output frac_pkg::unit_sts_t    sts,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int CW = (VALUE_WIDTH > 2) ? $clog2(VALUE_WIDTH) : 1;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_t;

  div_state_t             state;
  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] rem;
  logic [CW-1:0]          cnt;
  logic                   done;
  logic [VALUE_WIDTH:0]   rem_shift;
  logic [VALUE_WIDTH:0]   trial;

  // restoring division: one quotient bit per cycle, shifted into x
  assign rem_shift = {rem, x[VALUE_WIDTH-1]};
  assign trial     = rem_shift - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_RUN) && (cnt == '0);
      unique case (state)
        D_IDLE: begin
          if (ctl.start) begin
            x     <= dividend;
            d     <= divisor;
            rem   <= '0;
            cnt   <= CW'(VALUE_WIDTH - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (!trial[VALUE_WIDTH]) begin
            rem <= trial[VALUE_WIDTH-1:0];
            x   <= {x[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            rem <= rem_shift[VALUE_WIDTH-1:0];
            x   <= {x[VALUE_WIDTH-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= D_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign quotient = x;
  assign sts.done = done;
  assign sts.busy = (state != D_IDLE);

endmodule

FILE: design/fraction_reducer_top.sv
// one fraction at a time; the next transaction is taken once the result is in the output register
// a zero numerator or denominator goes straight to S_WR; otherwise the sequencer runs the binary gcd,
// then two bit-serial divisions (numerator, then denominator, each by the gcd), and S_WR then loads
// the output register
// a stalled output holds the input off
// reset is synchronous: it clears the sequencer, the units and the output valid
module fraction_reducer_top #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  frac_in_if.sink                fraction_in,
  frac_out_if.source             fraction_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_WR
  } top_state_t;

  top_state_t             state;
  logic [VALUE_WIDTH-1:0] num;
  logic [VALUE_WIDTH-1:0] den;
  logic [VALUE_WIDTH-1:0] gval;
  logic [VALUE_WIDTH-1:0] res_n;
  logic [VALUE_WIDTH-1:0] res_d;
  logic [VALUE_WIDTH-1:0] out_n;
  logic [VALUE_WIDTH-1:0] out_d;
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] div_a;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] g;
  frac_pkg::unit_ctl_t    gcd_ctl;
  frac_pkg::unit_ctl_t    div_ctl;
  frac_pkg::unit_sts_t    gcd_sts;
  frac_pkg::unit_sts_t    div_sts;
  logic                   in_xact;
  logic                   out_xact;
  logic                   gcd_go;
  logic                   div_go;

  assign in_xact  = fraction_in.valid && fraction_in.ready;
  assign out_xact = fraction_out.valid && fraction_out.ready;

  frac_gcd #(.VALUE_WIDTH(VALUE_WIDTH)) u_gcd (
    .clk (clk),
    .rst (rst),
    .ctl (gcd_ctl),
    .a   (num),
    .b   (den),
    .sts (gcd_sts),
    .g   (g)
  );

  frac_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_a),
    .divisor  (gval),
    .sts      (div_sts),
    .quotient (quo)
  );

  assign gcd_ctl.start = gcd_go && !gcd_sts.busy;
  assign div_ctl.start = div_go && !div_sts.busy;
  assign div_a         = (state == S_DIVD) ? den : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gcd_go    <= 1'b0;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      gcd_go <= (state == S_IDLE) && in_xact && (fraction_in.numerator != '0) &&
                (fraction_in.denominator != '0);
      div_go <= ((state == S_GCD) && gcd_sts.done) || ((state == S_DIVN) && div_sts.done);
      if ((state == S_WR) && (!out_valid || out_xact)) begin
        out_valid <= 1'b1;
      end else if (out_xact) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xact) begin
            num <= fraction_in.numerator;
            den <= fraction_in.denominator;
            if (fraction_in.numerator == '0) begin
              res_n <= '0;
              res_d <= VALUE_WIDTH'(1);
              state <= S_WR;
            end else if (fraction_in.denominator == '0) begin
              res_n <= fraction_in.numerator;
              res_d <= '0;
              state <= S_WR;
            end else begin
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          if (gcd_sts.done) begin
            gval  <= g;
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_sts.done) begin
            res_n <= quo;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_sts.done) begin
            res_d <= quo;
            state <= S_WR;
          end
        end
        // hand the result to the output register once it is free
        S_WR: begin
          if (!out_valid || out_xact) begin
            out_n <= res_n;
            out_d <= res_d;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign fraction_in.ready                = (state == S_IDLE);
  assign fraction_out.valid               = out_valid;
  assign fraction_out.reduced_numerator   = out_n;
  assign fraction_out.reduced_denominator = out_d;

endmodule
